/* design/mfpa_pkg.sv */
// Shared types and constants of the multi-frame pixel averaging block.
package mfpa_pkg;

    localparam int SAMPLE_W = 8;
    localparam int IMAGE_COUNT_W = 5;
    localparam int FRAME_LENGTH_W = 15;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [IMAGE_COUNT_W-1:0] IMAGE_COUNT_RESET = 5'd1;
    localparam logic [FRAME_LENGTH_W-1:0] FRAME_LENGTH_RESET = 15'd16384;

    localparam logic REG_IMAGE_COUNT = 1'b0;
    localparam logic REG_FRAME_LENGTH = 1'b1;

    typedef struct packed {
        logic first;
        logic last;
        logic eof;
    } mfpa_flags_t;

endpackage

/* design/mfpa_front.sv */
// Front part: byte and frame counters that classify each accepted item.
module mfpa_front import mfpa_pkg::*; #(
    parameter int FRAME_BYTES = 16384,
    parameter int MAX_IMAGES = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       clear,
    input  logic                                       accept,
    input  logic [$clog2(MAX_IMAGES+1)-1:0]            eff_count,
    input  logic [$clog2(FRAME_BYTES+1)-1:0]           eff_length,
    output logic [(FRAME_BYTES > 1 ? $clog2(FRAME_BYTES) : 1)-1:0] pos,
    output mfpa_flags_t                                flags
);

    localparam int CNT_W = $clog2(MAX_IMAGES + 1);
    localparam int LEN_W = $clog2(FRAME_BYTES + 1);
    localparam int POS_W = FRAME_BYTES > 1 ? $clog2(FRAME_BYTES) : 1;
    localparam int FN_W = MAX_IMAGES > 1 ? $clog2(MAX_IMAGES) : 1;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [FN_W-1:0]  fn_reg;
    logic [FN_W-1:0]  fn_next;

    always_comb
    begin
        flags.first = (fn_reg == '0);
        flags.last = (CNT_W'(fn_reg) == eff_count - CNT_W'(1));
        flags.eof = (LEN_W'(pos_reg) == eff_length - LEN_W'(1));
        pos = pos_reg;
        pos_next = pos_reg;
        fn_next = fn_reg;
        if (flags.eof)
        begin
            pos_next = '0;
            fn_next = flags.last ? '0 : fn_reg + FN_W'(1);
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            fn_reg <= '0;
        end
        else if (clear)
        begin
            pos_reg <= '0;
            fn_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            fn_reg <= fn_next;
        end
    end

endmodule

/* design/mfpa_queue.sv */
// Short first-in first-out queue between the front and back parts.
module mfpa_queue import mfpa_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* design/mfpa_back.sv */
// Back part: sum store read-modify-write, reciprocal divide and output register.
module mfpa_back import mfpa_pkg::*; #(
    parameter int FRAME_BYTES = 16384,
    parameter int MAX_IMAGES = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     q_empty,
    input  logic [SAMPLE_W + (FRAME_BYTES > 1 ? $clog2(FRAME_BYTES) : 1)
                  + $bits(mfpa_flags_t) - 1:0]       q_entry,
    output logic                                     q_pop,
    input  logic [$clog2(MAX_IMAGES+1)-1:0]          eff_count,
    output logic                                     result_valid,
    input  logic                                     result_ready,
    output logic [SAMPLE_W-1:0]                      average,
    output logic                                     end_of_frame
);

    localparam int CNT_W = $clog2(MAX_IMAGES + 1);
    localparam int POS_W = FRAME_BYTES > 1 ? $clog2(FRAME_BYTES) : 1;
    localparam int SUM_W = $clog2(MAX_IMAGES * 255 + 1);
    localparam int SHIFT = SUM_W + CNT_W;
    localparam int RCP_W = SHIFT + 1;
    localparam int PROD_W = SUM_W + RCP_W;

    logic [SUM_W-1:0] sum_mem [FRAME_BYTES];
    logic [RCP_W-1:0] recip_tab [MAX_IMAGES + 1];

    logic [SAMPLE_W-1:0] q_sample;
    logic [POS_W-1:0]    q_pos;
    mfpa_flags_t         q_flags;

    logic                b_valid_reg;
    logic [SAMPLE_W-1:0] b_sample_reg;
    logic [POS_W-1:0]    b_pos_reg;
    mfpa_flags_t         b_flags_reg;
    logic [SUM_W-1:0]    rd_data_reg;
    logic                lw_valid_reg;
    logic [POS_W-1:0]    lw_pos_reg;
    logic [SUM_W-1:0]    lw_sum_reg;

    logic                c_valid_reg;
    logic [SUM_W-1:0]    c_sum_reg;
    logic [RCP_W-1:0]    c_rcp_reg;
    logic                c_eof_reg;

    logic                d_valid_reg;
    logic [SAMPLE_W-1:0] average_reg;
    logic                eof_reg;

    logic [SUM_W-1:0]    stored;
    logic [SUM_W-1:0]    b_sum;
    logic [PROD_W-1:0]   product;
    logic                d_free;
    logic                c_free;
    logic                b_go;
    logic                b_free;
    logic                b_write;

    genvar g;
    generate
        for (g = 0; g <= MAX_IMAGES; g++)
        begin : g_recip
            localparam longint unsigned RCP =
                g == 0 ? 0 : ((64'd1 << SHIFT) + g - 1) / (g == 0 ? 1 : g);
            assign recip_tab[g] = RCP_W'(RCP);
        end
    endgenerate

    assign {q_sample, q_pos, q_flags} = q_entry;

    assign d_free = !d_valid_reg || result_ready;
    assign c_free = !c_valid_reg || d_free;
    assign b_go = b_valid_reg && (!b_flags_reg.last || c_free);
    assign b_free = !b_valid_reg || b_go;
    assign q_pop = !q_empty && b_free;
    assign b_write = b_go && !b_flags_reg.last;

    assign stored = (lw_valid_reg && lw_pos_reg == b_pos_reg) ? lw_sum_reg : rd_data_reg;
    assign b_sum = b_flags_reg.first ? SUM_W'(b_sample_reg)
                                     : stored + SUM_W'(b_sample_reg);
    assign product = PROD_W'(c_sum_reg) * PROD_W'(c_rcp_reg);

    assign result_valid = d_valid_reg;
    assign average = average_reg;
    assign end_of_frame = eof_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_data_reg <= sum_mem[q_pos];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_write)
        begin
            sum_mem[b_pos_reg] <= b_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b_sample_reg <= q_sample;
            b_pos_reg <= q_pos;
            b_flags_reg <= q_flags;
        end
        if (b_write)
        begin
            lw_pos_reg <= b_pos_reg;
            lw_sum_reg <= b_sum;
        end
        if (b_go && b_flags_reg.last)
        begin
            c_sum_reg <= b_sum;
            c_rcp_reg <= recip_tab[eff_count];
            c_eof_reg <= b_flags_reg.eof;
        end
        if (c_valid_reg && d_free)
        begin
            average_reg <= product[SHIFT +: SAMPLE_W];
            eof_reg <= c_eof_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_free)
            begin
                b_valid_reg <= q_pop;
            end
            if (b_write)
            begin
                lw_valid_reg <= 1'b1;
            end
            if (c_free)
            begin
                c_valid_reg <= b_go && b_flags_reg.last;
            end
            if (d_free)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

endmodule

/* design/multi_frame_pixel_average.sv */
// Top level of the multi-frame pixel averaging block with its register port.
//
// Usage: sample bytes of image_count frames, each frame_length bytes long in
// raster order, enter on the sample channel (sample_valid, sample_ready).
// During the first frames the bytes are summed into an internal store; during
// the last frame each byte yields one item on the result channel (result_valid,
// result_ready) carrying the truncated mean and an end_of_frame flag on the
// frame's final byte. Earlier frames produce no result items.
// Throughput is one byte per cycle while the result channel does not stall,
// set by the single-port-per-direction sum store doing one read and one write
// each cycle. After its byte is accepted, a result passes through the queue,
// the store read and the reciprocal multiply into the output register. When the
// receiver stalls, the output register holds, the back pipeline fills, then the
// four-entry queue fills and sample_ready drops. Reset clears the counters, the
// pipeline and the registers (image_count 1, frame_length 16384); the sum store
// needs no clearing because the first frame writes every entry before it is
// read. Any register write restarts the frame sequence.
module multi_frame_pixel_average import mfpa_pkg::*; #(
    parameter int FRAME_BYTES = 16384,
    parameter int MAX_IMAGES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [SAMPLE_W-1:0] average,
    output logic                end_of_frame
);

    localparam int CNT_W = $clog2(MAX_IMAGES + 1);
    localparam int LEN_W = $clog2(FRAME_BYTES + 1);
    localparam int POS_W = FRAME_BYTES > 1 ? $clog2(FRAME_BYTES) : 1;
    localparam int ENTRY_W = SAMPLE_W + POS_W + $bits(mfpa_flags_t);

    logic [IMAGE_COUNT_W-1:0]  image_count_reg;
    logic [FRAME_LENGTH_W-1:0] frame_length_reg;
    logic [CNT_W-1:0]          eff_count;
    logic [LEN_W-1:0]          eff_length;
    logic                      cfg_write;
    logic                      accept;
    logic [POS_W-1:0]          pos;
    mfpa_flags_t               flags;
    logic                      q_full;
    logic                      q_empty;
    logic                      q_pop;
    logic [ENTRY_W-1:0]        q_entry;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign sample_ready = !q_full;
    assign accept = sample_valid && sample_ready;

    always_comb
    begin
        unique case (paddr[2])
            REG_IMAGE_COUNT:  prdata = 32'(image_count_reg);
            REG_FRAME_LENGTH: prdata = 32'(frame_length_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        if (image_count_reg == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (32'(image_count_reg) > MAX_IMAGES)
        begin
            eff_count = CNT_W'(MAX_IMAGES);
        end
        else
        begin
            eff_count = CNT_W'(image_count_reg);
        end
        if (frame_length_reg == '0)
        begin
            eff_length = LEN_W'(1);
        end
        else if (32'(frame_length_reg) > FRAME_BYTES)
        begin
            eff_length = LEN_W'(FRAME_BYTES);
        end
        else
        begin
            eff_length = LEN_W'(frame_length_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_count_reg <= IMAGE_COUNT_RESET;
            frame_length_reg <= FRAME_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_IMAGE_COUNT:  image_count_reg <= pwdata[IMAGE_COUNT_W-1:0];
                REG_FRAME_LENGTH: frame_length_reg <= pwdata[FRAME_LENGTH_W-1:0];
                default:          image_count_reg <= image_count_reg;
            endcase
        end
    end

    mfpa_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .MAX_IMAGES  (MAX_IMAGES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (cfg_write),
        .accept     (accept),
        .eff_count  (eff_count),
        .eff_length (eff_length),
        .pos        (pos),
        .flags      (flags)
    );

    mfpa_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   ({sample, pos, flags}),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_entry),
        .empty (q_empty)
    );

    mfpa_back #(
        .FRAME_BYTES (FRAME_BYTES),
        .MAX_IMAGES  (MAX_IMAGES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .eff_count    (eff_count),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .average      (average),
        .end_of_frame (end_of_frame)
    );

endmodule

/* design/mfpa_checker.sv */
// Port-level checks of the multi-frame pixel averaging block and their binding.
module mfpa_checker import mfpa_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                sample_valid,
    input logic                sample_ready,
    input logic                result_valid,
    input logic                result_ready,
    input logic [SAMPLE_W-1:0] average,
    input logic                end_of_frame
);

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(average) && $stable(end_of_frame))
        else $error("A stalled result item changed or vanished.");

    assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("A result item is offered during reset.");

    assert property (@(posedge clk) !rst_n |-> sample_ready)
        else $error("The input side is not ready during reset.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sample_ready) |-> $past(sample_valid && sample_ready))
        else $error("The input side stopped accepting without taking an item.");

endmodule

bind multi_frame_pixel_average mfpa_checker u_mfpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .average      (average),
    .end_of_frame (end_of_frame)
);
